// ===== sv/manchester_frame_receiver_unit_defines.svh =====
// Assertion macros used by the receiver back end.
`ifndef MANCHESTER_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define MANCHESTER_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define MFRU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("receiver assertion failed");

`define MFRU_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("receiver forbidden condition seen");

`else

`define MFRU_ASSERT(lbl, clk, rstn, prop)

`define MFRU_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== sv/mfru_pkg.sv =====
// Types and constants shared by the Manchester frame receiver modules.
`timescale 1ns / 1ps

package mfru_pkg;

  localparam int unsigned TsWidth       = 32;
  localparam int unsigned ThrWidth      = 16;
  localparam int unsigned BitCntWidth   = 6;
  localparam int unsigned FrameBits     = 32;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned InDataWidth   = 40;
  localparam int unsigned OutDataWidth  = 72;

  localparam logic [ThrWidth-1:0]    ThrReset  = 16'd750;
  localparam logic [BitCntWidth-1:0] FrameCnt  = 6'd32;

  // Operation codes on the input tuser.
  localparam logic [1:0] OpArm  = 2'd0;
  localparam logic [1:0] OpEdge = 2'd1;
  localparam logic [1:0] OpStop = 2'd2;

  // Latched error codes.
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrStopBit = 2'd1;
  localparam logic [1:0] ErrParity  = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_LISTEN   = 3'd1,
    MODE_READ     = 3'd2,
    MODE_RECEIVED = 3'd3,
    MODE_ERROR    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CMD_ARM  = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_STOP = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [TsWidth-1:0]  ts;
    logic                level;
  } cmd_t;

endpackage

// ===== sv/manchester_frame_receiver_unit.sv =====
// Top level of the Manchester frame receiver: front end, command queue and back end.
`timescale 1ns / 1ps

// The receiver takes one event word per clock cycle while the queue has room
// and returns exactly one result word for each. A word entering on the slave
// side is decoded and written into a short command queue; the back end takes
// one command per cycle from the queue while the result register is free or
// being taken, updates the frame state and loads the result register. The
// result register and the queue decouple the two sides: the slave side keeps
// accepting while a result waits, until the queue fills.
// The threshold register may be written only while no word is in flight.
module manchester_frame_receiver_unit import mfru_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ThrWidth-1:0]     cfg_wdata_i,     // half_bit_threshold_us
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [31:0] timestamp_us, [32] line_level, [39:33] zero
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]              s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [2:0] receiver_mode, [3] message_ready, [6:4] frame_type, [14:7] data_id,
  // [30:15] data_value, [32:31] error_code, [64:33] error_frame,
  // [70:65] error_bit_position, [71] zero
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic q_full, q_empty, q_pop;

  assign s_axis_tready = !q_full;

  mfru_front u_front (
    .op_i   (s_axis_tuser),
    .data_i (s_axis_tdata),
    .cmd_o  (front_cmd)
  );

  mfru_queue #(
    .Width ($bits(cmd_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (queue_cmd),
    .empty_o     (q_empty)
  );

  mfru_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== sv/mfru_front.sv =====
// Front end: decodes an incoming word into a receiver command.
`timescale 1ns / 1ps

module mfru_front import mfru_pkg::*; (
  input  logic [1:0]             op_i,
  input  logic [InDataWidth-1:0] data_i,
  output cmd_t                   cmd_o
);

  always_comb begin
    cmd_o.ts    = data_i[TsWidth-1:0];
    cmd_o.level = data_i[TsWidth];
    case (op_i)
      OpArm:   cmd_o.kind = CMD_ARM;
      OpEdge:  cmd_o.kind = CMD_EDGE;
      OpStop:  cmd_o.kind = CMD_STOP;
      default: cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== sv/mfru_queue.sv =====
// Small first-in first-out queue between the front end and the back end.
`timescale 1ns / 1ps

module mfru_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrWidth = $clog2(Depth);
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

  logic [Width-1:0]    mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/mfru_back.sv =====
// Back end: frame decoding state and the registered result word.
`timescale 1ns / 1ps
`include "manchester_frame_receiver_unit_defines.svh"

module mfru_back import mfru_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ThrWidth-1:0]     cfg_wdata_i,
  input  cmd_t                    cmd_i,
  input  logic                    cmd_valid_i,
  output logic                    cmd_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OutDataWidth-1:0] out_data_o
);

  mode_e                  mode_q, mode_d;
  logic                   start_q, start_d;
  logic [TsWidth-1:0]     last_q, last_d;
  logic [FrameBits-1:0]   shift_q, shift_d;
  logic [BitCntWidth-1:0] cnt_q, cnt_d;
  logic [1:0]             err_q, err_d;
  logic [FrameBits-1:0]   err_frame_q, err_frame_d;
  logic [BitCntWidth-1:0] err_bits_q, err_bits_d;
  logic [ThrWidth-1:0]    thr_q;
  logic                   out_valid_q;
  logic [OutDataWidth-1:0] out_data_q, out_data_d;

  logic [TsWidth-1:0] spacing;
  logic               near;
  logic               ready;

  assign cmd_pop_o   = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Spacing wraps with the free-running timestamp.
  assign spacing = cmd_i.ts - last_q;
  assign near    = spacing < {{(TsWidth-ThrWidth){1'b0}}, thr_q};

  always_comb begin
    mode_d      = mode_q;
    start_d     = start_q;
    last_d      = last_q;
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    err_frame_d = err_frame_q;
    err_bits_d  = err_bits_q;
    case (cmd_i.kind)
      CMD_ARM: begin
        mode_d  = MODE_LISTEN;
        shift_d = '0;
        cnt_d   = '0;
        start_d = cmd_i.level;
        if (cmd_i.level) begin
          last_d = cmd_i.ts;
        end
      end
      CMD_EDGE: begin
        case (mode_q)
          MODE_LISTEN: begin
            if (cmd_i.level) begin
              start_d = 1'b1;
              last_d  = cmd_i.ts;
            end else if (start_q && near) begin
              mode_d  = MODE_READ;
              shift_d = '0;
              cnt_d   = '0;
              last_d  = cmd_i.ts;
              start_d = 1'b0;
            end else begin
              start_d = 1'b0;
            end
          end
          MODE_READ: begin
            // Edges closer than the threshold are mid-bit transitions.
            if (!near) begin
              last_d = cmd_i.ts;
              if (cnt_q < FrameCnt) begin
                shift_d = {shift_q[FrameBits-2:0], ~cmd_i.level};
                cnt_d   = cnt_q + 1'b1;
              end else if (!cmd_i.level && !(^shift_q)) begin
                mode_d = MODE_RECEIVED;
              end else begin
                mode_d      = MODE_ERROR;
                err_d       = cmd_i.level ? ErrStopBit : ErrParity;
                err_frame_d = shift_q;
                err_bits_d  = cnt_q;
              end
            end
          end
          default: begin
          end
        endcase
      end
      CMD_STOP: mode_d = MODE_IDLE;
      default: begin
      end
    endcase
  end

  always_comb begin
    ready      = (mode_d == MODE_RECEIVED);
    out_data_d = '0;
    out_data_d[2:0]   = mode_d;
    out_data_d[3]     = ready;
    out_data_d[6:4]   = ready ? shift_d[30:28] : 3'd0;
    out_data_d[14:7]  = ready ? shift_d[23:16] : 8'd0;
    out_data_d[30:15] = ready ? shift_d[15:0]  : 16'd0;
    out_data_d[32:31] = err_d;
    out_data_d[64:33] = err_frame_d;
    out_data_d[70:65] = err_bits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      start_q     <= 1'b0;
      last_q      <= '0;
      shift_q     <= '0;
      cnt_q       <= '0;
      err_q       <= ErrNone;
      err_frame_q <= '0;
      err_bits_q  <= '0;
      thr_q       <= ThrReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_pop_o) begin
        mode_q      <= mode_d;
        start_q     <= start_d;
        last_q      <= last_d;
        shift_q     <= shift_d;
        cnt_q       <= cnt_d;
        err_q       <= err_d;
        err_frame_q <= err_frame_d;
        err_bits_q  <= err_bits_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_data_q <= out_data_d;
    end
  end

  `MFRU_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > FrameCnt)
  `MFRU_ASSERT(a_ready_mode, clk_i, rst_ni, out_valid_q && out_data_q[3] |-> out_data_q[2:0] == MODE_RECEIVED)
  `MFRU_ASSERT(a_stop_idle, clk_i, rst_ni, cmd_pop_o && cmd_i.kind == CMD_STOP |=> mode_q == MODE_IDLE)
  `MFRU_ASSERT(a_err_clean, clk_i, rst_ni, err_q == ErrNone |-> err_frame_q == '0 && err_bits_q == '0)

endmodule

// ===== tb/sv/tb_manchester_frame_receiver_unit.sv =====
// Self-checking testbench for the Manchester frame receiver: directed corners, then random frames.
`timescale 1ns / 1ps

module tb_manchester_frame_receiver_unit import mfru_pkg::*; ();

  localparam int unsigned TimeLimitNs = 10_000_000;
  localparam int unsigned MaxReports  = 10;

  // Members run from the highest result bits down to the lowest.
  typedef struct packed {
    logic [5:0]  err_bits;
    logic [31:0] err_frame;
    logic [1:0]  err_code;
    logic [15:0] data_value;
    logic [7:0]  data_id;
    logic [2:0]  msg_type;
    logic        ready;
    mode_e       mode;
  } rx_status_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [ThrWidth-1:0]     cfg_wdata_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // [31:0] timestamp_us, [32] line_level, [39:33] zero
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  // [1:0] operation
  logic [1:0]              s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [2:0] mode, [3] ready, [6:4] type, [14:7] id, [30:15] value, [32:31] error,
  // [64:33] error frame, [70:65] error bit position, [71] zero
  logic [OutDataWidth-1:0] m_axis_tdata;

  manchester_frame_receiver_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Decoder state mirrored by the testbench.
  mode_e          rx_mode;
  logic           start_seen;
  logic [31:0]    last_edge_us;
  logic [31:0]    frame_sr;
  logic [5:0]     bit_cnt;
  logic [1:0]     err_code;
  logic [31:0]    err_frame;
  logic [5:0]     err_bits;
  logic [15:0]    threshold_us;

  rx_status_t     predicted_status_q[$];
  rx_status_t     want;
  rx_status_t     seen;
  rx_status_t     fresh;
  int unsigned    words_sent = 0;
  int unsigned    words_checked = 0;
  int unsigned    mismatches = 0;
  int unsigned    stim_thr = ThrReset;
  bit             calm = 1'b0;

  task automatic latch_fault(input logic [1:0] code);
    err_code  = code;
    err_frame = frame_sr;
    err_bits  = bit_cnt;
    rx_mode   = MODE_ERROR;
  endtask

  task automatic decode_event(input cmd_kind_e kind, input logic [31:0] ts, input logic lvl,
                              output rx_status_t res);
    logic [31:0] spacing;
    logic        below;
    spacing = ts - last_edge_us;
    below   = spacing < {16'd0, threshold_us};
    case (kind)
      CMD_ARM: begin
        rx_mode    = MODE_LISTEN;
        frame_sr   = '0;
        bit_cnt    = '0;
        start_seen = lvl;
        // A high line on arming counts as an already seen rising start edge.
        if (lvl) last_edge_us = ts;
      end
      CMD_EDGE: begin
        if (rx_mode == MODE_LISTEN) begin
          if (lvl) begin
            start_seen   = 1'b1;
            last_edge_us = ts;
          end else if (start_seen && below) begin
            rx_mode      = MODE_READ;
            frame_sr     = '0;
            bit_cnt      = '0;
            last_edge_us = ts;
            start_seen   = 1'b0;
          end else begin
            start_seen = 1'b0;
          end
        end else if (rx_mode == MODE_READ && !below) begin
          last_edge_us = ts;
          if (bit_cnt < FrameCnt) begin
            frame_sr = {frame_sr[30:0], ~lvl};
            bit_cnt  = bit_cnt + 6'd1;
          end else if (lvl) begin
            latch_fault(ErrStopBit);
          end else if (^frame_sr) begin
            latch_fault(ErrParity);
          end else begin
            rx_mode = MODE_RECEIVED;
          end
        end
      end
      CMD_STOP: rx_mode = MODE_IDLE;
      default: ;
    endcase
    res            = '0;
    res.mode       = rx_mode;
    res.ready      = (rx_mode == MODE_RECEIVED);
    if (res.ready) begin
      res.msg_type   = frame_sr[30:28];
      res.data_id    = frame_sr[23:16];
      res.data_value = frame_sr[15:0];
    end
    res.err_code   = err_code;
    res.err_frame  = err_frame;
    res.err_bits   = err_bits;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("result %0d: %s expected 0x%0h, got 0x%0h", words_checked, name, exp_v, got_v);
    end
  endtask

  // Predicts on every accepted event word and checks every accepted result word.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_mode      = MODE_IDLE;
      start_seen   = 1'b0;
      last_edge_us = '0;
      frame_sr     = '0;
      bit_cnt      = '0;
      err_code     = ErrNone;
      err_frame    = '0;
      err_bits     = '0;
      threshold_us = ThrReset;
    end else begin
      if (cfg_we_i) threshold_us = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_event(cmd_kind_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[32], fresh);
        predicted_status_q.push_back(fresh);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata[70:0];
        if (predicted_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("result %0d arrived with no event pending: 0x%0h",
                     words_checked, m_axis_tdata);
        end else begin
          want = predicted_status_q.pop_front();
          check_field("receiver_mode", want.mode, seen.mode);
          check_field("message_ready", want.ready, seen.ready);
          check_field("frame_type", want.msg_type, seen.msg_type);
          check_field("data_id", want.data_id, seen.data_id);
          check_field("data_value", want.data_value, seen.data_value);
          check_field("error_code", want.err_code, seen.err_code);
          check_field("error_frame", want.err_frame, seen.err_frame);
          check_field("error_bit_position", want.err_bits, seen.err_bits);
        end
        words_checked++;
      end
    end
  end

  // Result side stalls about a quarter of the time except during calm stretches.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 24);
  end

  task automatic send_word(input cmd_kind_e kind, input logic [31:0] ts, input logic lvl);
    while (!calm && $urandom_range(0, 99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, lvl, ts};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (predicted_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_threshold(input int unsigned value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[15:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    stim_thr = value;
    @(posedge clk_i);
  endtask

  function automatic int unsigned mid_gap();
    return (stim_thr == 0) ? 0 : $urandom_range(0, stim_thr - 1);
  endfunction

  function automatic int unsigned bit_gap();
    return stim_thr + $urandom_range(0, stim_thr);
  endfunction

  task automatic send_noise(input int n);
    cmd_kind_e kind;
    for (int k = 0; k < n; k++) begin
      kind = ($urandom_range(0, 3) == 0) ? cmd_kind_e'($urandom_range(0, 3)) : CMD_EDGE;
      send_word(kind, $urandom(), $urandom_range(0, 1));
    end
  endtask

  // Sends one frame as line edges; cut_at stops it before that bit (-1 before the stop bit).
  task automatic send_frame(input logic [31:0] frame, input logic stop_lvl, input int cut_at);
    logic [31:0] t;
    logic        line;
    logic        target;
    t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40000) : $urandom();
    if ($urandom_range(0, 3) == 0) begin
      send_word(CMD_ARM, t, 1'b1);
    end else begin
      send_word(CMD_ARM, t, 1'b0);
      if ($urandom_range(0, 7) == 0) begin
        // A start pulse that is too long is dropped and listening goes on.
        t += $urandom_range(1, 2000);
        send_word(CMD_EDGE, t, 1'b1);
        t += stim_thr + $urandom_range(0, 50);
        send_word(CMD_EDGE, t, 1'b0);
      end
      t += $urandom_range(1, 2000);
      send_word(CMD_EDGE, t, 1'b1);
    end
    t += mid_gap();
    send_word(CMD_EDGE, t, 1'b0);
    line = 1'b0;
    for (int i = 31; i >= -1; i--) begin
      if (i == cut_at) break;
      target = (i >= 0) ? ~frame[i] : stop_lvl;
      // Equal levels in a row need a transition at the bit boundary.
      if (line == target) send_word(CMD_EDGE, t + mid_gap(), ~target);
      t += bit_gap();
      send_word(CMD_EDGE, t, target);
      line = target;
    end
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        t += $urandom_range(0, 3 * stim_thr + 10);
        send_word(CMD_EDGE, t, $urandom_range(0, 1));
      end
    end
    if ($urandom_range(0, 1) == 0) send_word(CMD_STOP, t, $urandom_range(0, 1));
  endtask

  task automatic run_frames(input int unsigned n);
    int unsigned stop_at;
    int unsigned kind;
    logic [31:0] frame;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        send_noise($urandom_range(1, 4));
      end else begin
        frame = $urandom();
        if (kind >= 25 && ^frame) frame[31] = ~frame[31];
        send_frame(frame, kind >= 90,
                   (kind >= 80 && kind < 90) ? int'($urandom_range(0, 32)) - 1 : -2);
      end
    end
  endtask

  task automatic test_event_corners();
    send_word(CMD_NOP, 32'h0000_0000, 1'b0);
    send_word(CMD_EDGE, 32'hFFFF_FFFF, 1'b1);
    send_word(CMD_STOP, 32'h0000_0000, 1'b0);
    send_word(CMD_ARM, 32'd1000, 1'b0);
    send_word(CMD_EDGE, 32'd1100, 1'b0);
    send_word(CMD_EDGE, 32'd2000, 1'b1);
    send_word(CMD_EDGE, 32'd2750, 1'b0);
    send_word(CMD_NOP, 32'hFFFF_FFFF, 1'b1);
    // Start bit straddling the timestamp wrap.
    send_word(CMD_ARM, 32'hFFFF_FF00, 1'b1);
    send_word(CMD_EDGE, 32'h0000_01E0, 1'b0);
    send_word(CMD_EDGE, 32'h0000_01E0 + 749, 1'b1);
    send_word(CMD_EDGE, 32'h0000_01E0 + 750, 1'b1);
    send_word(CMD_EDGE, 32'h0000_01E0 + 1500, 1'b0);
    send_word(CMD_NOP, 32'h5555_AAAA, 1'b0);
    send_word(CMD_ARM, 32'h0000_0000, 1'b0);
    send_word(CMD_EDGE, 32'd5, 1'b1);
    send_word(CMD_EDGE, 32'd5, 1'b0);
    send_word(CMD_STOP, 32'hFFFF_FFFF, 1'b1);
    send_word(CMD_EDGE, 32'hAAAA_5555, 1'b0);
  endtask

  task automatic test_frames_reset_threshold();
    run_frames(350);
  endtask

  task automatic test_threshold_extremes();
    int unsigned corner[3] = '{1, 65535, 0};
    foreach (corner[k]) begin
      set_threshold(corner[k]);
      run_frames(150);
    end
  endtask

  task automatic test_random_thresholds();
    repeat (3) begin
      set_threshold($urandom_range(1, 65535));
      run_frames(150);
    end
  endtask

  task automatic test_back_to_back();
    set_threshold(ThrReset);
    calm = 1'b1;
    run_frames(200);
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_event_corners();
    test_frames_reset_threshold();
    test_threshold_extremes();
    test_random_thresholds();
    test_back_to_back();
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #(TimeLimitNs);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mfru_pkg.sv
sv/mfru_front.sv
sv/mfru_queue.sv
sv/mfru_back.sv
sv/manchester_frame_receiver_unit.sv
tb/sv/tb_manchester_frame_receiver_unit.sv
